// ===== hdl/gwpl_pkg.sv =====
// shared widths, configuration types and register indexes for the gain and peak limiter
package gwpl_pkg;

   localparam int SAMPLE_W   = 32;
   localparam int THR_W      = 31;
   localparam int LG_W       = 16;
   localparam int CNT_W      = 32;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;
   localparam int FRAC_W     = 16;

   // shared multiplier: 33-bit signed operands, product kept to 64 bits
   localparam int MUL_OP_W = 33;
   localparam int PROD_W   = 64;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_GAIN        = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_USE_LIMITER = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LIM_THRESH  = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LIM_GAIN    = 8'd3;

   // reset values
   localparam logic signed [SAMPLE_W-1:0] GAIN_RST = 32'sd65536;
   localparam logic [THR_W-1:0]           THR_RST  = 31'h7fff_ffff;
   localparam logic [LG_W-1:0]            LG_RST   = 16'd3277;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] gain;
      logic                       use_limiter;
      logic [THR_W-1:0]           limiter_threshold;
      logic [LG_W-1:0]            limiter_gain;
   } cfg_type;

endpackage

// ===== hdl/gwpl_ifs.sv =====
// valid/ready channel interfaces for samples, results and register writes

interface gwpl_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [gwpl_pkg::SAMPLE_W-1:0] in_sample;
   logic                                buffer_end;
   modport source (output valid, in_sample, buffer_end, input ready);
   modport sink   (input valid, in_sample, buffer_end, output ready);
endinterface

interface gwpl_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [gwpl_pkg::SAMPLE_W-1:0] out_sample;
   logic                                was_limited;
   logic                                was_clipped;
   logic [gwpl_pkg::CNT_W-1:0]          limited_total;
   logic [gwpl_pkg::CNT_W-1:0]          clipped_total;
   logic                                end_flag;
   modport source (output valid, out_sample, was_limited, was_clipped, limited_total,
                   clipped_total, end_flag, input ready);
   modport sink   (input valid, out_sample, was_limited, was_clipped, limited_total,
                   clipped_total, end_flag, output ready);
endinterface

interface gwpl_csr_if;
   logic                                valid;
   logic                                ready;
   logic [gwpl_pkg::CSR_IDX_W-1:0]      index;
   logic [gwpl_pkg::CSR_DATA_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/gwpl_csr.sv =====
// configuration registers: gain, limiter enable, threshold and slope
module gwpl_csr (
   input  logic                clock,
   input  logic                reset,
   gwpl_csr_if.sink            csr_bus,
   output gwpl_pkg::cfg_type   cfg
);

   gwpl_pkg::cfg_type cfg_ff;
   gwpl_pkg::cfg_type cfg_in;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            gwpl_pkg::REG_GAIN:        cfg_in.gain = csr_bus.data[gwpl_pkg::SAMPLE_W-1:0];
            gwpl_pkg::REG_USE_LIMITER: cfg_in.use_limiter = csr_bus.data[0];
            gwpl_pkg::REG_LIM_THRESH:
               cfg_in.limiter_threshold = csr_bus.data[gwpl_pkg::THR_W-1:0];
            gwpl_pkg::REG_LIM_GAIN:    cfg_in.limiter_gain = csr_bus.data[gwpl_pkg::LG_W-1:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain              <= gwpl_pkg::GAIN_RST;
         cfg_ff.use_limiter       <= 1'b0;
         cfg_ff.limiter_threshold <= gwpl_pkg::THR_RST;
         cfg_ff.limiter_gain      <= gwpl_pkg::LG_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/gwpl_mul.sv =====
// registered signed multiplier shared by the gain and limiter paths
module gwpl_mul (
   input  logic                                   clock,
   input  logic                                   en,
   input  logic signed [gwpl_pkg::MUL_OP_W-1:0]   op_a,
   input  logic signed [gwpl_pkg::MUL_OP_W-1:0]   op_b,
   output logic signed [gwpl_pkg::PROD_W-1:0]     prod
);

   logic signed [2*gwpl_pkg::MUL_OP_W-1:0] full;
   logic signed [gwpl_pkg::PROD_W-1:0]     prod_ff;
   logic signed [gwpl_pkg::PROD_W-1:0]     prod_in;

   assign full    = op_a * op_b;
   // the selected products always fit in 64 signed bits
   assign prod_in = full[gwpl_pkg::PROD_W-1:0];

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

// ===== hdl/gain_with_peak_limiter_unit.sv =====
// top level: gain stage with soft peak limiter, five-stage pipeline
//
//   channel   port      direction  beat carries
//   -------   --------  ---------  --------------------------------------------------
//   samples   req_bus   in         in_sample, buffer_end
//   results   rsp_bus   out        out_sample, was_limited, was_clipped, totals, end_flag
//   config    csr_bus   in         index, data (always ready)
//
// one beat per cycle sustained while rsp_bus is ready; a sample passes through the stage 1
// to stage 5 registers in order to reach the output register; the 33x33 multiplier in stage 2 sets the stage depth
// reset clears all valid bits, both saturating counters and loads default config
// each stage loads when it is empty or the stage after it moves, so a stall on
// rsp_bus holds everything in place and gaps between beats close up
module gain_with_peak_limiter_unit #(
   parameter int SAMPLE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   gwpl_csr_if.sink    csr_bus,
   gwpl_req_if.sink    req_bus,
   gwpl_rsp_if.source  rsp_bus
);

   // clip limits in full precision and scaled by 2^16
   localparam logic signed [63:0] SMAX_W = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
   localparam logic signed [63:0] SMIN_W = -SMAX_W - 64'sd1;
   localparam logic signed [63:0] SMAX_Q = SMAX_W <<< gwpl_pkg::FRAC_W;
   localparam logic signed [63:0] SMIN_Q = SMIN_W <<< gwpl_pkg::FRAC_W;
   localparam logic signed [63:0] ROUND_BIAS = (64'sd1 <<< gwpl_pkg::FRAC_W) - 64'sd1;

   gwpl_pkg::cfg_type cfg;

   gwpl_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   // stage enables, back to front
   logic en1, en2, en3, en4, en5;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;

   assign en5 = !v5_ff || rsp_bus.ready;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign req_bus.ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_bus.valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
      end
   end

   // ---------------------------------------------------------------------------
   // stage 1: threshold tests and multiplier operand selection
   // ---------------------------------------------------------------------------
   logic signed [32:0] s_ext;
   logic signed [32:0] thr_ext;
   logic signed [33:0] s_w;
   logic signed [33:0] smax_w;
   logic signed [33:0] dist_pos;   // distance to full scale, positive side
   logic signed [33:0] dist_neg;   // distance to full scale, negative side
   logic               lim_pos_in, lim_neg_in;
   logic signed [gwpl_pkg::MUL_OP_W-1:0] opa_in, opb_in;

   logic               s1_lim_pos_ff, s1_lim_neg_ff, s1_end_ff;
   logic signed [gwpl_pkg::MUL_OP_W-1:0] s1_opa_ff, s1_opb_ff;

   assign s_ext   = {req_bus.in_sample[gwpl_pkg::SAMPLE_W-1], req_bus.in_sample};
   assign thr_ext = {2'b00, cfg.limiter_threshold};
   assign s_w     = {{2{req_bus.in_sample[gwpl_pkg::SAMPLE_W-1]}}, req_bus.in_sample};
   assign smax_w  = SMAX_W[33:0];
   assign dist_pos = smax_w - s_w;
   assign dist_neg = smax_w + s_w;

   assign lim_pos_in = cfg.use_limiter && (s_ext > thr_ext);
   assign lim_neg_in = cfg.use_limiter && (s_ext < -thr_ext);

   always_comb begin
      priority if (lim_pos_in) begin
         opa_in = dist_pos[gwpl_pkg::MUL_OP_W-1:0];
         opb_in = {{(gwpl_pkg::MUL_OP_W - gwpl_pkg::LG_W){1'b0}}, cfg.limiter_gain};
      end else if (lim_neg_in) begin
         opa_in = dist_neg[gwpl_pkg::MUL_OP_W-1:0];
         opb_in = {{(gwpl_pkg::MUL_OP_W - gwpl_pkg::LG_W){1'b0}}, cfg.limiter_gain};
      end else begin
         opa_in = s_ext;
         opb_in = {cfg.gain[gwpl_pkg::SAMPLE_W-1], cfg.gain};
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_opa_ff     <= opa_in;
         s1_opb_ff     <= opb_in;
         s1_lim_pos_ff <= lim_pos_in;
         s1_lim_neg_ff <= lim_neg_in;
         s1_end_ff     <= req_bus.buffer_end;
      end
   end

   // ---------------------------------------------------------------------------
   // stage 2: gain * sample or slope * distance
   // ---------------------------------------------------------------------------
   logic signed [gwpl_pkg::PROD_W-1:0] s2_prod;
   logic s2_lim_pos_ff, s2_lim_neg_ff, s2_end_ff;

   gwpl_mul u_mul (
      .clock (clock),
      .en    (en2),
      .op_a  (s1_opa_ff),
      .op_b  (s1_opb_ff),
      .prod  (s2_prod)
   );

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_lim_pos_ff <= s1_lim_pos_ff;
         s2_lim_neg_ff <= s1_lim_neg_ff;
         s2_end_ff     <= s1_end_ff;
      end
   end

   // ---------------------------------------------------------------------------
   // stage 3: exact result scaled by 2^16
   // ---------------------------------------------------------------------------
   logic signed [63:0] num_in;
   logic signed [63:0] s3_num_ff;
   logic s3_lim_pos_ff, s3_lim_neg_ff, s3_end_ff;

   always_comb begin
      priority if (s2_lim_pos_ff) begin
         num_in = SMAX_Q - s2_prod;
      end else if (s2_lim_neg_ff) begin
         num_in = s2_prod - SMAX_Q;   // sign restored on the negative side
      end else begin
         num_in = s2_prod;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_num_ff     <= num_in;
         s3_lim_pos_ff <= s2_lim_pos_ff;
         s3_lim_neg_ff <= s2_lim_neg_ff;
         s3_end_ff     <= s2_end_ff;
      end
   end

   // ---------------------------------------------------------------------------
   // stage 4: clip tests and truncation toward zero
   // ---------------------------------------------------------------------------
   logic               over_hi, over_lo;
   logic signed [63:0] biased;
   logic [gwpl_pkg::SAMPLE_W-1:0] res_in;
   logic               clip_in;

   logic [gwpl_pkg::SAMPLE_W-1:0] s4_res_ff;
   logic s4_limited_ff, s4_clipped_ff, s4_end_ff;

   assign over_hi = s3_num_ff > SMAX_Q;
   assign over_lo = s3_num_ff < SMIN_Q;
   // negative values get 2^16-1 added so the shift truncates toward zero
   assign biased  = s3_num_ff + (s3_num_ff[63] ? ROUND_BIAS : 64'sd0);
   // a limiter result on the negative side that leaves the range pins to a rail without a clip count
   assign clip_in = (over_hi || over_lo) && !s3_lim_neg_ff;

   always_comb begin
      priority if (over_lo) begin
         res_in = SMIN_W[gwpl_pkg::SAMPLE_W-1:0];
      end else if (over_hi) begin
         res_in = SMAX_W[gwpl_pkg::SAMPLE_W-1:0];
      end else begin
         res_in = biased[gwpl_pkg::FRAC_W +: gwpl_pkg::SAMPLE_W];
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         s4_res_ff     <= res_in;
         s4_limited_ff <= s3_lim_pos_ff || s3_lim_neg_ff;
         s4_clipped_ff <= clip_in;
         s4_end_ff     <= s3_end_ff;
      end
   end

   // ---------------------------------------------------------------------------
   // stage 5: output register and saturating counters
   // the counters move only when a beat enters the output register, so they
   // always hold the totals of the beat on display
   // ---------------------------------------------------------------------------
   logic [gwpl_pkg::CNT_W-1:0] lim_cnt_ff, lim_cnt_in;
   logic [gwpl_pkg::CNT_W-1:0] clip_cnt_ff, clip_cnt_in;
   logic                       load5;

   logic [gwpl_pkg::SAMPLE_W-1:0] s5_res_ff;
   logic s5_limited_ff, s5_clipped_ff, s5_end_ff;

   assign load5 = en5 && v4_ff;

   always_comb begin
      lim_cnt_in  = lim_cnt_ff;
      clip_cnt_in = clip_cnt_ff;
      if (load5 && s4_limited_ff && (lim_cnt_ff != gwpl_pkg::CNT_MAX)) begin
         lim_cnt_in = lim_cnt_ff + 1'b1;
      end
      if (load5 && s4_clipped_ff && (clip_cnt_ff != gwpl_pkg::CNT_MAX)) begin
         clip_cnt_in = clip_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_cnt_ff  <= '0;
         clip_cnt_ff <= '0;
      end else begin
         lim_cnt_ff  <= lim_cnt_in;
         clip_cnt_ff <= clip_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         s5_res_ff     <= s4_res_ff;
         s5_limited_ff <= s4_limited_ff;
         s5_clipped_ff <= s4_clipped_ff;
         s5_end_ff     <= s4_end_ff;
      end
   end

   assign rsp_bus.valid         = v5_ff;
   assign rsp_bus.out_sample    = s5_res_ff;
   assign rsp_bus.was_limited   = s5_limited_ff;
   assign rsp_bus.was_clipped   = s5_clipped_ff;
   assign rsp_bus.limited_total = lim_cnt_ff;
   assign rsp_bus.clipped_total = clip_cnt_ff;
   assign rsp_bus.end_flag      = s5_end_ff;

   // ---------------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------------

   // a clipped beat sits exactly at one rail of the sample range
   a_clip_at_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.was_clipped) |->
         (rsp_bus.out_sample == SMAX_W[gwpl_pkg::SAMPLE_W-1:0] ||
          rsp_bus.out_sample == SMIN_W[gwpl_pkg::SAMPLE_W-1:0]))
      else $error("clipped beat not at a rail");

   // every result stays inside the configured sample range
   a_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |->
         ($signed(rsp_bus.out_sample) <= SMAX_W && $signed(rsp_bus.out_sample) >= SMIN_W))
      else $error("result outside sample range");

   // counters step by at most one, and only for a beat entering the output register
   a_lim_cnt_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(lim_cnt_ff) |->
         ($past(load5 && s4_limited_ff) && lim_cnt_ff == $past(lim_cnt_ff) + 1'b1))
      else $error("limited count moved without a limited beat");

   a_clip_cnt_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(clip_cnt_ff) |->
         ($past(load5 && s4_clipped_ff) && clip_cnt_ff == $past(clip_cnt_ff) + 1'b1))
      else $error("clip count moved without a clipped beat");

endmodule
